@@ hw/rtl/record_table_sort_delete_defines.svh @@
// Assertion macros for the record table RTL.
// Depends on nothing; included by files that assert.
`ifndef RECORD_TABLE_SORT_DELETE_DEFINES_SVH
`define RECORD_TABLE_SORT_DELETE_DEFINES_SVH
// assert that a implies b on the same edge
`define RTS_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define RTS_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/rts_pkg.sv @@
// Types, codes and constants for the record table.
// Depends on nothing.
package rts_pkg;
    localparam int DEPTH_DEFAULT = 256;
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SORT   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] rec_id;
        logic [15:0] key_mark;
        logic [7:0]  base_flag;
        logic [7:0]  grant_flag;
        logic [7:0]  read_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] out_id;
        logic [15:0] out_key;
        logic [7:0]  out_base;
        logic [7:0]  out_grant;
        logic [8:0]  entry_count;
    } t_out_word;

    typedef struct packed {
        logic [30:0] id;
        logic [15:0] key;
        logic [15:0] flags;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_APPEND, S_RD_ISSUE, S_RD_WAIT, S_RD_DONE,
        S_FIND, S_FIND_CHK, S_SHIFT_RD, S_SHIFT_WR,
        S_SORT_START, S_SORT_RD, S_SORT_CMP, S_SORT_WR, S_SORT_NEXT, S_DONE
    } t_state;
endpackage

@@ hw/rtl/rts_front.sv @@
// Front end: two-entry input queue that holds accepted command words.
// Depends on rts_pkg.
module rts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  rts_pkg::t_in_word i_word,
    output logic              o_valid,
    output rts_pkg::t_in_word o_word,
    input  logic              i_take
);
    logic [1:0]        r_count, n_count;
    logic              r_rd, n_rd, r_wr, n_wr;
    rts_pkg::t_in_word r_q [2];

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_q[r_rd];

    always_comb begin
        n_count = r_count;
        n_rd = r_rd;
        n_wr = r_wr;
        if (i_push && !o_full) begin
            n_wr = ~r_wr;
            n_count = n_count + 2'd1;
        end
        if (i_take && o_valid) begin
            n_rd = ~r_rd;
            n_count = n_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wr] <= i_word;
        end
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end
endmodule

@@ hw/rtl/rts_back.sv @@
// Back end: table memory and sequencer for append, delete, sort and read.
// Depends on rts_pkg and the assertion macro header.
`include "record_table_sort_delete_defines.svh"
module rts_back #(
    parameter int DEPTH = rts_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rts_pkg::t_in_word  i_word,
    output logic               o_take,
    output logic               o_res_valid,
    output rts_pkg::t_out_word o_res,
    input  logic               i_res_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rts_pkg::t_entry  r_mem [DEPTH];
    rts_pkg::t_entry  r_rdata, r_hold;
    rts_pkg::t_in_word r_cmd, n_cmd;
    rts_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_left, n_left, r_right, n_right;
    logic             r_dir, n_dir;
    logic             r_res_v, n_res_v;
    rts_pkg::t_out_word r_res, n_res;
    rts_pkg::t_out_word r_acc, n_acc;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    rts_pkg::t_entry  mem_wdata;
    logic             hold_ld;

    assign o_res_valid = r_res_v;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
        if (hold_ld) begin
            r_hold <= r_rdata;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_fill = r_fill;
        n_idx = r_idx;
        n_left = r_left;
        n_right = r_right;
        n_dir = r_dir;
        n_res_v = r_res_v;
        n_res = r_res;
        n_acc = r_acc;
        o_take = 1'b0;
        mem_we = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_raddr = r_idx[AW-1:0];
        mem_wdata = r_rdata;
        hold_ld = 1'b0;
        if (r_res_v && i_res_pop) begin
            n_res_v = 1'b0;
        end
        unique case (r_state)
            rts_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    n_cmd = i_word;
                    n_idx = '0;
                    unique case (i_word.opcode)
                        rts_pkg::OP_APPEND: n_state = rts_pkg::S_APPEND;
                        rts_pkg::OP_DELETE: n_state = rts_pkg::S_FIND;
                        rts_pkg::OP_SORT:   n_state = rts_pkg::S_SORT_START;
                        default:            n_state = rts_pkg::S_RD_ISSUE;
                    endcase
                end
            end
            rts_pkg::S_APPEND: begin
                n_acc = '0;
                if (r_fill >= CW'(DEPTH)) begin
                    n_acc.status = rts_pkg::ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = r_fill[AW-1:0];
                    mem_wdata.id = r_cmd.rec_id;
                    mem_wdata.key = r_cmd.key_mark;
                    mem_wdata.flags = {r_cmd.grant_flag, r_cmd.base_flag};
                    n_fill = r_fill + CW'(1);
                end
                n_state = rts_pkg::S_DONE;
            end
            rts_pkg::S_RD_ISSUE: begin
                n_acc = '0;
                if (32'(r_cmd.read_index) >= 32'(r_fill)
                    || 32'(r_cmd.read_index) >= 32'(DEPTH)) begin
                    n_acc.status = rts_pkg::ST_BAD_INDEX;
                    n_state = rts_pkg::S_DONE;
                end else begin
                    mem_raddr = AW'(r_cmd.read_index);
                    n_state = rts_pkg::S_RD_WAIT;
                end
            end
            rts_pkg::S_RD_WAIT: begin
                mem_raddr = AW'(r_cmd.read_index);
                n_state = rts_pkg::S_RD_DONE;
            end
            rts_pkg::S_RD_DONE: begin
                n_acc.out_id = r_rdata.id;
                n_acc.out_key = r_rdata.key;
                n_acc.out_base = r_rdata.flags[7:0];
                n_acc.out_grant = r_rdata.flags[15:8];
                n_state = rts_pkg::S_DONE;
            end
            rts_pkg::S_FIND: begin
                n_acc = '0;
                if (r_idx >= r_fill) begin
                    n_acc.status = rts_pkg::ST_NOT_FOUND;
                    n_state = rts_pkg::S_DONE;
                end else begin
                    n_state = rts_pkg::S_FIND_CHK;
                end
            end
            rts_pkg::S_FIND_CHK: begin
                if (r_rdata.id == r_cmd.rec_id) begin
                    n_state = rts_pkg::S_SHIFT_RD;
                end else begin
                    n_idx = r_idx + CW'(1);
                    n_state = rts_pkg::S_FIND;
                end
            end
            rts_pkg::S_SHIFT_RD: begin
                if (r_idx + CW'(1) >= r_fill) begin
                    n_fill = r_fill - CW'(1);
                    n_state = rts_pkg::S_DONE;
                end else begin
                    mem_raddr = AW'(r_idx + CW'(1));
                    n_state = rts_pkg::S_SHIFT_WR;
                end
            end
            rts_pkg::S_SHIFT_WR: begin
                mem_we = 1'b1;
                n_idx = r_idx + CW'(1);
                n_state = rts_pkg::S_SHIFT_RD;
            end
            rts_pkg::S_SORT_START: begin
                n_acc = '0;
                if (r_fill < CW'(2)) begin
                    n_state = rts_pkg::S_DONE;
                end else begin
                    n_left = '0;
                    n_right = r_fill - CW'(1);
                    n_dir = 1'b0;
                    n_idx = r_fill - CW'(2);
                    n_state = rts_pkg::S_SORT_RD;
                end
            end
            rts_pkg::S_SORT_RD: begin
                mem_raddr = r_idx[AW-1:0];
                n_state = rts_pkg::S_SORT_CMP;
            end
            rts_pkg::S_SORT_CMP: begin
                hold_ld = 1'b1;
                mem_raddr = AW'(r_idx + CW'(1));
                n_state = rts_pkg::S_SORT_WR;
            end
            rts_pkg::S_SORT_WR: begin
                mem_raddr = AW'(r_idx + CW'(1));
                if (r_hold.key > r_rdata.key) begin
                    mem_we = 1'b1;
                    mem_waddr = r_idx[AW-1:0];
                    mem_wdata = r_rdata;
                    n_state = rts_pkg::S_SORT_NEXT;
                end else begin
                    n_state = rts_pkg::S_SORT_NEXT;
                    n_idx = r_idx;
                end
            end
            rts_pkg::S_SORT_NEXT: begin
                if (r_hold.key > r_rdata.key) begin
                    mem_we = 1'b1;
                    mem_waddr = AW'(r_idx + CW'(1));
                    mem_wdata = r_hold;
                end
                n_state = rts_pkg::S_SORT_RD;
                if (!r_dir) begin
                    if (r_idx > r_left) begin
                        n_idx = r_idx - CW'(1);
                    end else begin
                        n_left = r_left + CW'(1);
                        n_dir = 1'b1;
                        n_idx = r_left + CW'(1);
                        if (r_left + CW'(1) >= r_right) begin
                            n_state = rts_pkg::S_DONE;
                        end
                    end
                end else begin
                    if (r_idx + CW'(2) < r_right + CW'(1)) begin
                        n_idx = r_idx + CW'(1);
                    end else begin
                        n_right = r_right - CW'(1);
                        n_dir = 1'b0;
                        n_idx = r_right - CW'(2);
                        if (r_left >= r_right - CW'(1)) begin
                            n_state = rts_pkg::S_DONE;
                        end
                    end
                end
            end
            rts_pkg::S_DONE: begin
                if (!r_res_v || i_res_pop) begin
                    n_res = r_acc;
                    n_res.entry_count = 9'(r_fill);
                    n_res_v = 1'b1;
                    n_state = rts_pkg::S_IDLE;
                end
            end
            default: n_state = rts_pkg::S_IDLE;
        endcase
        if (r_state == rts_pkg::S_FIND) begin
            mem_raddr = r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_left <= n_left;
        r_right <= n_right;
        r_dir <= n_dir;
        r_res <= n_res;
        r_acc <= n_acc;
        if (!i_rst_n) begin
            r_state <= rts_pkg::S_IDLE;
            r_fill <= '0;
            r_res_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_res_v <= n_res_v;
        end
    end

    `RTS_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH))
    `RTS_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_take, r_state == rts_pkg::S_IDLE)
    `RTS_ASSERT_NEXT(a_done_res, i_clk, i_rst_n,
        r_state == rts_pkg::S_DONE && n_state == rts_pkg::S_IDLE, r_res_v)
endmodule

@@ hw/rtl/record_table_sort_delete.sv @@
// Record table with append, delete by id, stable cocktail sort and read.
// Append and read touch a single entry, delete walks the entries to the match
// and shifts each later entry down, and sort compares neighbor pairs in
// alternating passes, all set by the table memory walked one entry per step.
module record_table_sort_delete #(
    parameter int DEPTH = rts_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rts_pkg::t_in_word  i_in,
    output logic               empty,
    input  logic               pop,
    output rts_pkg::t_out_word o_out
);
    logic              f_valid, f_take, r_valid;
    rts_pkg::t_in_word f_word;

    rts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_word(i_in), .o_valid(f_valid), .o_word(f_word), .i_take(f_take)
    );

    rts_back #(.DEPTH(DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_word(f_word),
        .o_take(f_take), .o_res_valid(r_valid), .o_res(o_out), .i_res_pop(pop)
    );

    assign empty = !r_valid;
endmodule

@@ tb/sv/tb_record_table_sort_delete.sv @@
// Self-checking testbench for record_table_sort_delete: append, delete, sort and read
// words are pushed with random gaps and checked against a table model kept here.
// Depends on rts_pkg and the record_table_sort_delete RTL.
`timescale 1ns / 1ps

module tb_record_table_sort_delete;

    localparam int DEPTH = rts_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 40000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full;
    logic               empty;
    rts_pkg::t_in_word  i_in = '0;
    rts_pkg::t_out_word o_out;

    record_table_sort_delete #(.DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in(i_in), .empty(empty), .pop(pop), .o_out(o_out)
    );

    always #5 i_clk = ~i_clk;

    rts_pkg::t_entry    table_model[$];
    rts_pkg::t_in_word  pending_words[$];
    rts_pkg::t_out_word expected_words[$];
    int        errors = 0;
    int        cycles = 0;
    int        words_sent = 0;
    int        words_checked = 0;
    int        sorts_run = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        hold_off = 0;
    bit        hold_done = 0;
    logic      push_taken = 1'b0;
    logic      pop_taken = 1'b0;

    function automatic rts_pkg::t_out_word predict_table_op(rts_pkg::t_in_word w);
        rts_pkg::t_out_word r;
        rts_pkg::t_entry    tmp;
        int        lo;
        int        hi;
        int        pos;
        r = '0;
        r.status = rts_pkg::ST_OK;
        case (w.opcode)
            rts_pkg::OP_APPEND: begin
                if (table_model.size() >= DEPTH) begin
                    r.status = rts_pkg::ST_FULL;
                end else begin
                    tmp.id = w.rec_id;
                    tmp.key = w.key_mark;
                    tmp.flags = {w.grant_flag, w.base_flag};
                    table_model.push_back(tmp);
                end
            end
            rts_pkg::OP_DELETE: begin
                pos = -1;
                foreach (table_model[i]) begin
                    if (pos < 0 && table_model[i].id == w.rec_id) pos = i;
                end
                if (pos < 0) r.status = rts_pkg::ST_NOT_FOUND;
                else table_model.delete(pos);
            end
            rts_pkg::OP_SORT: begin
                lo = 0;
                hi = table_model.size() - 1;
                while (lo < hi) begin
                    for (int i = hi; i > lo; i--) begin
                        if (table_model[i-1].key > table_model[i].key) begin
                            tmp = table_model[i-1];
                            table_model[i-1] = table_model[i];
                            table_model[i] = tmp;
                        end
                    end
                    lo++;
                    for (int i = lo; i < hi; i++) begin
                        if (table_model[i].key > table_model[i+1].key) begin
                            tmp = table_model[i];
                            table_model[i] = table_model[i+1];
                            table_model[i+1] = tmp;
                        end
                    end
                    hi--;
                end
            end
            default: begin
                if (w.read_index >= table_model.size()) begin
                    r.status = rts_pkg::ST_BAD_INDEX;
                end else begin
                    tmp = table_model[w.read_index];
                    r.out_id = tmp.id;
                    r.out_key = tmp.key;
                    r.out_base = tmp.flags[7:0];
                    r.out_grant = tmp.flags[15:8];
                end
            end
        endcase
        r.entry_count = 9'(table_model.size());
        return r;
    endfunction

    function automatic rts_pkg::t_in_word make_word(logic [1:0] op, logic [30:0] id,
                                                    logic [15:0] key, logic [7:0] idx);
        rts_pkg::t_in_word w;
        w.opcode = op;
        w.rec_id = id;
        w.key_mark = key;
        w.base_flag = 8'($urandom);
        w.grant_flag = 8'($urandom);
        w.read_index = idx;
        return w;
    endfunction

    always @(posedge i_clk) begin
        push_taken <= i_rst_n && push && !full;
        pop_taken <= i_rst_n && pop && !empty;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (push && !push_taken) begin
                // hold until accepted
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_in <= pending_words.pop_front();
                push <= 1'b1;
                send_gap <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            expected_words.push_back(predict_table_op(i_in));
            if (i_in.opcode == rts_pkg::OP_SORT) sorts_run++;
            words_sent++;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rts_pkg::t_out_word exp_w;
        if (i_rst_n && pop && !empty) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                $error("unexpected word: %p", o_out);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out.status !== exp_w.status) begin
                    $error("status exp %0d got %0d", exp_w.status, o_out.status); errors++;
                end
                if (o_out.out_id !== exp_w.out_id) begin
                    $error("out_id exp %0h got %0h", exp_w.out_id, o_out.out_id); errors++;
                end
                if (o_out.out_key !== exp_w.out_key) begin
                    $error("out_key exp %0h got %0h", exp_w.out_key, o_out.out_key); errors++;
                end
                if (o_out.out_base !== exp_w.out_base) begin
                    $error("out_base exp %0h got %0h", exp_w.out_base, o_out.out_base); errors++;
                end
                if (o_out.out_grant !== exp_w.out_grant) begin
                    $error("out_grant exp %0h got %0h", exp_w.out_grant, o_out.out_grant);
                    errors++;
                end
                if (o_out.entry_count !== exp_w.entry_count) begin
                    $error("entry_count exp %0d got %0d", exp_w.entry_count,
                           o_out.entry_count);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= (hold_off == 1);
        end else if (!hold_done && words_checked >= 40) begin
            hold_done <= 1'b1;
            hold_off <= 3000;
            pop <= 1'b0;
        end else if (pop_taken) begin
            gap = $urandom_range(0, 15);
            recv_gap <= gap;
            pop <= (gap == 0);
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            pop <= (recv_gap == 1);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycles,
                     expected_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n;
        logic [1:0] op;
        logic [30:0] id_pick;
        pending_words.push_back(make_word(rts_pkg::OP_SORT, '0, '0, '0));
        pending_words.push_back(make_word(rts_pkg::OP_READ, '0, '0, 8'd0));
        pending_words.push_back(make_word(rts_pkg::OP_DELETE, 31'h7fffffff, '0, '0));
        pending_words.push_back(make_word(rts_pkg::OP_APPEND, 31'h7fffffff, 16'hffff, '0));
        pending_words.push_back(make_word(rts_pkg::OP_SORT, '0, '0, '0));
        pending_words.push_back(make_word(rts_pkg::OP_APPEND, 31'd0, 16'h0000, '0));
        pending_words.push_back(make_word(rts_pkg::OP_APPEND, 31'd5, 16'h0100, '0));
        pending_words.push_back(make_word(rts_pkg::OP_APPEND, 31'd5, 16'h0100, '0));
        pending_words.push_back(make_word(rts_pkg::OP_APPEND, 31'd9, 16'h0080, '0));
        pending_words.push_back(make_word(rts_pkg::OP_SORT, '0, '0, '0));
        for (int i = 0; i < 5; i++)
            pending_words.push_back(make_word(rts_pkg::OP_READ, '0, '0, 8'(i)));
        pending_words.push_back(make_word(rts_pkg::OP_READ, '0, '0, 8'hff));
        pending_words.push_back(make_word(rts_pkg::OP_DELETE, 31'd5, '0, '0));
        pending_words.push_back(make_word(rts_pkg::OP_DELETE, 31'd1234, '0, '0));
        pending_words.push_back(make_word(rts_pkg::OP_READ, '0, '0, 8'd1));
        // fill to the brim, overflow, sort full, read top, drain partly
        for (int i = 0; i < DEPTH; i++)
            pending_words.push_back(make_word(rts_pkg::OP_APPEND,
                                              31'($urandom_range(0, 40)),
                                              16'($urandom), '0));
        pending_words.push_back(make_word(rts_pkg::OP_APPEND, 31'd1, 16'd1, '0));
        pending_words.push_back(make_word(rts_pkg::OP_SORT, '0, '0, '0));
        pending_words.push_back(make_word(rts_pkg::OP_READ, '0, '0, 8'hff));
        pending_words.push_back(make_word(rts_pkg::OP_READ, '0, '0, 8'h00));
        n = 0;
        while (n < 720) begin
            op = 2'($urandom_range(0, 3));
            if (op == rts_pkg::OP_SORT && $urandom_range(0, 9) != 0) op = rts_pkg::OP_READ;
            id_pick = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
            pending_words.push_back(make_word(op, id_pick,
                ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7))),
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 48))));
            n++;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() == 0 && !push);
        wait (expected_words.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("covered %0d words (%0d sorts), %0d results checked, %0d entries left",
                 words_sent, sorts_run, words_checked, table_model.size());
        if (errors == 0 && expected_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
